>>> design/lpsd_pkg.sv
// ----------------------------------------------------------------------------
// lpsd_pkg
// Shared types and constants of the length-prefixed string deframer.
// ----------------------------------------------------------------------------
package lpsd_pkg;

	localparam int DEF_LENGTH_BITS = 32;
	localparam int QUEUE_DEPTH     = 4;

	localparam int MORE_BIT  = 7;
	localparam int GROUP_W   = 7;

	localparam logic [1:0] KIND_BODY  = 2'd0;
	localparam logic [1:0] KIND_EMPTY = 2'd1;
	localparam logic [1:0] KIND_ERROR = 2'd2;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data;
		logic       last;
	} res_t;

endpackage

>>> design/lpsd_front.sv
// ----------------------------------------------------------------------------
// lpsd_front
// Prefix parser: gathers the length prefix, counts body bytes and emits
// one result record per byte that causes one.
// ----------------------------------------------------------------------------
module lpsd_front #(
	parameter int LENGTH_BITS = lpsd_pkg::DEF_LENGTH_BITS
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           take,
	input  logic [7:0]     in_byte,
	output logic           res_valid,
	output lpsd_pkg::res_t res
);

	localparam int MAX_PREFIX = (LENGTH_BITS + 6) / 7;
	localparam int CNT_W      = (MAX_PREFIX > 1) ? $clog2(MAX_PREFIX) : 1;
	localparam int GRP_VEC_W  = lpsd_pkg::GROUP_W * MAX_PREFIX;

	logic                   in_body_q;
	logic [LENGTH_BITS-1:0] length_q;
	logic [CNT_W-1:0]       count_q;
	logic [LENGTH_BITS-1:0] left_q;

	logic [GRP_VEC_W-1:0]   grp;
	logic [LENGTH_BITS-1:0] acc_next;
	logic [CNT_W:0]         count_inc;
	logic                   overlong;
	logic                   more;
	logic [LENGTH_BITS-1:0] left_dec;
	logic                   res_hit;

	always_comb begin
		grp = '0;
		for (int g = 0; g < MAX_PREFIX; g++) begin
			if (count_q == CNT_W'(g)) begin
				grp[lpsd_pkg::GROUP_W*g +: lpsd_pkg::GROUP_W] =
					in_byte[lpsd_pkg::GROUP_W-1:0];
			end
		end
	end

	assign acc_next  = length_q | grp[LENGTH_BITS-1:0];
	assign count_inc = {1'b0, count_q} + (CNT_W+1)'(1);
	assign overlong  = count_inc >= (CNT_W+1)'(MAX_PREFIX);
	assign more      = in_byte[lpsd_pkg::MORE_BIT];
	assign left_dec  = left_q - LENGTH_BITS'(1);

	always_comb begin
		res_hit   = 1'b0;
		res.kind  = lpsd_pkg::KIND_BODY;
		res.data  = 8'd0;
		res.last  = 1'b0;
		priority if (in_body_q) begin
			res_hit  = 1'b1;
			res.data = in_byte;
			res.last = (left_dec == '0);
		end else if (more) begin
			if (overlong) begin
				res_hit  = 1'b1;
				res.kind = lpsd_pkg::KIND_ERROR;
				res.last = 1'b1;
			end
		end else begin
			if (acc_next == '0) begin
				res_hit  = 1'b1;
				res.kind = lpsd_pkg::KIND_EMPTY;
				res.last = 1'b1;
			end
		end
	end

	assign res_valid = take & res_hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_body_q <= 1'b0;
			length_q  <= '0;
			count_q   <= '0;
			left_q    <= '0;
		end else if (take) begin
			priority if (in_body_q) begin
				left_q <= left_dec;
				if (left_dec == '0) begin
					in_body_q <= 1'b0;
				end
			end else if (more) begin
				if (overlong) begin
					length_q <= '0;
					count_q  <= '0;
				end else begin
					length_q <= acc_next;
					count_q  <= count_inc[CNT_W-1:0];
				end
			end else begin
				length_q <= '0;
				count_q  <= '0;
				if (acc_next != '0) begin
					left_q    <= acc_next;
					in_body_q <= 1'b1;
				end
			end
		end
	end

	a_res_needs_take: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> take)
		else $error("result without accepted byte");

	a_body_has_left: assert property (@(posedge clk) disable iff (!arst_n)
		in_body_q |-> (left_q != '0))
		else $error("body state with no bytes left");

	a_marker_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && (res.kind == lpsd_pkg::KIND_ERROR || res.kind == lpsd_pkg::KIND_EMPTY))
		|-> (res.last && res.data == 8'd0))
		else $error("marker result malformed");

endmodule

>>> design/lpsd_queue.sv
// ----------------------------------------------------------------------------
// lpsd_queue
// Result queue: holds records from the parser until the consumer pops them.
// ----------------------------------------------------------------------------
module lpsd_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_en,
	input  lpsd_pkg::res_t wr_data,
	output logic           full,
	output logic           empty,
	input  logic           rd_en,
	output lpsd_pkg::res_t rd_data
);

	localparam int DEPTH = lpsd_pkg::QUEUE_DEPTH;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	lpsd_pkg::res_t entry_q [DEPTH];
	logic [AW-1:0]  wr_ptr_q;
	logic [AW-1:0]  rd_ptr_q;
	logic [AW:0]    count_q;
	logic           push_ok;
	logic           pop_ok;

	assign full    = (count_q == (AW+1)'(DEPTH));
	assign empty   = (count_q == '0);
	assign push_ok = wr_en & ~full;
	assign pop_ok  = rd_en & ~empty;
	assign rd_data = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push_ok) begin
			entry_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_ok) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH-1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (pop_ok) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH-1)) ? '0 : rd_ptr_q + AW'(1);
			end
			unique case ({push_ok, pop_ok})
				2'b10:   count_q <= count_q + (AW+1)'(1);
				2'b01:   count_q <= count_q - (AW+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (AW+1)'(DEPTH))
		else $error("queue count beyond depth");

	a_count_steady: assert property (@(posedge clk) disable iff (!arst_n)
		(push_ok && pop_ok) |=> $stable(count_q))
		else $error("count moved on push with pop");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(push_ok && !pop_ok) |=> !empty)
		else $error("queue empty after push");

endmodule

>>> design/length_prefixed_string_deframer.sv
// ----------------------------------------------------------------------------
// length_prefixed_string_deframer
// Splits a byte stream of length-prefixed strings into body bytes, empty
// string markers and overlong prefix errors.
// ----------------------------------------------------------------------------
// Takes one byte per cycle whenever full is low, and results can be popped
// one per cycle while empty is low; a byte goes through the prefix parser in
// the cycle it is pushed, and its result, if any, is visible on the result
// side the next cycle. A four-entry result queue separates the two sides, so
// push stalls only once four results wait unpopped. Each string starts with a
// little-endian prefix of 7-bit groups, bit 7 meaning another prefix byte
// follows; prefix bytes give no result except an empty string (kind 1) or an
// overlong prefix error (kind 2) after ceil(LENGTH_BITS/7) continuing bytes.
// Body bytes come out as kind 0, the final one with out_last set.
module length_prefixed_string_deframer #(
	parameter int LENGTH_BITS = lpsd_pkg::DEF_LENGTH_BITS
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] in_byte,
	output logic       empty,
	input  logic       pop,
	output logic [1:0] out_kind,
	output logic [7:0] out_byte,
	output logic       out_last
);

	logic           take;
	logic           res_valid;
	lpsd_pkg::res_t res;
	lpsd_pkg::res_t head;

	assign take = push & ~full;

	lpsd_front #(
		.LENGTH_BITS (LENGTH_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.in_byte   (in_byte),
		.res_valid (res_valid),
		.res       (res)
	);

	lpsd_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_valid),
		.wr_data (res),
		.full    (full),
		.empty   (empty),
		.rd_en   (pop),
		.rd_data (head)
	);

	assign out_kind = head.kind;
	assign out_byte = head.data;
	assign out_last = head.last;

endmodule

>>> verif/length_prefixed_string_deframer_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// length_prefixed_string_deframer_tb
// Self-checking testbench of the length-prefixed string deframer.
// ----------------------------------------------------------------------------
// Pushes a byte stream of length-prefixed strings and pops the deframed
// results, both sides with random gaps. A scoreboard predicts the result of
// every accepted byte and compares every popped result field by field. The
// stream opens with directed strings (empty, padded, wide and overlong
// prefixes), then mixes random strings with overlong and wide prefixes. The
// receiver holds off twice for a long stretch so the result queue fills.
// ----------------------------------------------------------------------------
module length_prefixed_string_deframer_tb;

	localparam int LEN_W       = lpsd_pkg::DEF_LENGTH_BITS;
	localparam int GRP_W       = lpsd_pkg::GROUP_W;
	localparam int MAX_PREFIX  = (LEN_W + GRP_W - 1) / GRP_W;
	localparam int ITEM_TARGET = 1400;
	localparam int MAX_GAP     = 18;
	localparam int HOLD_CYCLES = 400;
	localparam int STALL_LIMIT = 2000;
	localparam int MAX_REPORTS = 10;

	class string_scoreboard;
		lpsd_pkg::res_t   expected_results[$];
		bit               in_body      = 1'b0;
		logic [LEN_W-1:0] length_accum = '0;
		logic [LEN_W-1:0] bytes_left   = '0;
		logic [2:0]       prefix_count = '0;
		int               failures     = 0;
		int               checked      = 0;
		int               body_count   = 0;
		int               empty_count  = 0;
		int               error_count  = 0;

		function void note_byte(logic [7:0] b);
			logic [63:0]      merged;
			logic [LEN_W-1:0] total;
			if (in_body) begin
				bytes_left = bytes_left - LEN_W'(1);
				expected_results.push_back('{lpsd_pkg::KIND_BODY, b,
					bytes_left == '0});
				body_count++;
				if (bytes_left == '0) begin
					in_body = 1'b0;
				end
				return;
			end
			merged = {{(64 - LEN_W){1'b0}}, length_accum}
				| ({57'd0, b[GRP_W-1:0]} << (GRP_W * prefix_count));
			length_accum = merged[LEN_W-1:0];
			if (b[lpsd_pkg::MORE_BIT]) begin
				prefix_count = prefix_count + 3'd1;
				if (prefix_count >= MAX_PREFIX) begin
					length_accum = '0;
					prefix_count = '0;
					expected_results.push_back('{lpsd_pkg::KIND_ERROR, 8'h00, 1'b1});
					error_count++;
				end
				return;
			end
			total        = length_accum;
			length_accum = '0;
			prefix_count = '0;
			if (total == '0) begin
				expected_results.push_back('{lpsd_pkg::KIND_EMPTY, 8'h00, 1'b1});
				empty_count++;
			end else begin
				bytes_left = total;
				in_body    = 1'b1;
			end
		endfunction

		function void check_result(logic [1:0] kind, logic [7:0] data, logic last);
			lpsd_pkg::res_t want;
			checked++;
			if (expected_results.size() == 0) begin
				if (failures < MAX_REPORTS) begin
					$display("unexpected result: kind=%0d byte=%02h last=%0d",
						kind, data, last);
				end
				failures++;
				return;
			end
			want = expected_results.pop_front();
			if (kind !== want.kind || data !== want.data || last !== want.last) begin
				if (failures < MAX_REPORTS) begin
					$display({"mismatch at result %0d: expected kind=%0d byte=%02h ",
						"last=%0d, got kind=%0d byte=%02h last=%0d"},
						checked, want.kind, want.data, want.last, kind, data, last);
				end
				failures++;
			end
		endfunction

		function int pending();
			return expected_results.size();
		endfunction
	endclass

	logic       clk    = 1'b0;
	logic       arst_n = 1'b0;
	logic       push   = 1'b0;
	logic [7:0] in_byte = 8'h00;
	logic       pop    = 1'b0;
	logic       full;
	logic       empty;
	logic [1:0] out_kind;
	logic [7:0] out_byte;
	logic       out_last;

	string_scoreboard sb = new;
	int               sent_count  = 0;
	int               idle_cycles = 0;
	int               send_mode   = 1;

	length_prefixed_string_deframer dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.in_byte  (in_byte),
		.empty    (empty),
		.pop      (pop),
		.out_kind (out_kind),
		.out_byte (out_byte),
		.out_last (out_last)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic int draw_gap(int mode);
		unique case (mode)
			0: return 0;
			1: return $urandom_range(0, MAX_GAP);
			default: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, MAX_GAP) : 0;
		endcase
	endfunction

	task automatic send_byte(logic [7:0] b);
		int gap;
		if ($urandom_range(0, 63) == 0) begin
			send_mode = $urandom_range(0, 2);
		end
		gap = draw_gap(send_mode);
		if (gap > 0) begin
			push    <= 1'b0;
			in_byte <= 8'($urandom_range(0, 255));
			repeat (gap) @(negedge clk);
		end
		push    <= 1'b1;
		in_byte <= b;
		do @(posedge clk); while (full);
		sb.note_byte(b);
		sent_count++;
		@(negedge clk);
	endtask

	task automatic send_prefix(int unsigned len, int groups);
		for (int i = 0; i < groups; i++) begin
			send_byte({i < groups - 1, 7'((len >> (GRP_W * i)) & 32'h7f)});
		end
	endtask

	task automatic send_body(int unsigned len);
		for (int unsigned i = 0; i < len; i++) begin
			send_byte(8'($urandom_range(0, 255)));
		end
	endtask

	task automatic send_overlong();
		for (int i = 0; i < MAX_PREFIX; i++) begin
			send_byte(8'h80 | 8'($urandom_range(0, 127)));
		end
	endtask

	task automatic send_random_stream();
		int          pick;
		int unsigned len;
		int          groups;
		while (sent_count < ITEM_TARGET) begin
			pick = $urandom_range(0, 99);
			if (pick < 8) begin
				send_overlong();
			end else if (pick < 14) begin
				len = $urandom_range(0, 15);
				send_byte(8'h80 | 8'(len));
				repeat (MAX_PREFIX - 2) send_byte(8'h80);
				send_byte({1'b0, 3'($urandom_range(0, 7)), 4'h0});
				send_body(len);
			end else if (pick < 18) begin
				len = $urandom_range(100, 300);
				send_prefix(len, 2);
				send_body(len);
			end else begin
				len    = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 12);
				groups = ($urandom_range(0, 3) == 0) ? $urandom_range(1, MAX_PREFIX - 1) : 1;
				send_prefix(len, groups);
				send_body(len);
			end
		end
	endtask

	initial begin : byte_side
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_byte(8'h00);
		send_byte(8'h02);
		send_byte(8'h00);
		send_byte(8'hff);
		send_byte(8'h80);
		send_byte(8'h00);
		send_byte(8'h80);
		send_byte(8'hff);
		send_byte(8'hd5);
		send_byte(8'h80);
		send_byte(8'haa);
		send_byte(8'h80);
		send_byte(8'h80);
		send_byte(8'h80);
		send_byte(8'h80);
		send_byte(8'h70);
		send_byte(8'h82);
		send_byte(8'h80);
		send_byte(8'h80);
		send_byte(8'h80);
		send_byte(8'h10);
		send_byte(8'h80);
		send_byte(8'h7f);

		send_random_stream();
		push <= 1'b0;

		while (sb.pending() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.pending() != 0) begin
			$display("%0d expected results never arrived", sb.pending());
			sb.failures += sb.pending();
		end

		$display("Pushed %0d bytes: %0d body bytes, %0d empty strings, %0d overlong prefixes.",
			sent_count, sb.body_count, sb.empty_count, sb.error_count);
		$display("Checked %0d results, %0d failures.", sb.checked, sb.failures);
		if (sb.failures == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	initial begin : result_side
		int mode;
		int gap;
		int popped;
		mode   = 1;
		popped = 0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if ($urandom_range(0, 63) == 0) begin
				mode = $urandom_range(0, 2);
			end
			gap = draw_gap(mode);
			if (popped == 300 || popped == 900) begin
				gap = HOLD_CYCLES;
			end
			if (gap > 0) begin
				pop <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty);
			sb.check_result(out_kind, out_byte, out_last);
			popped++;
			@(negedge clk);
		end
	end

	initial begin : watchdog
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((push && !full) || (pop && !empty)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
		end
		$display("no transaction for %0d cycles, %0d results still expected",
			STALL_LIMIT, sb.pending());
		$display("Simulation FAILED");
		$finish;
	end

endmodule

>>> sim.f
design/lpsd_pkg.sv
design/lpsd_front.sv
design/lpsd_queue.sv
design/length_prefixed_string_deframer.sv
verif/length_prefixed_string_deframer_tb.sv
